// ----- rtl/edc_pkg.sv -----
package edc_pkg;

	// field widths
	localparam int POS_W  = 16;
	localparam int DIAM_W = 14;
	localparam int MASS_W = 16;
	localparam int VEL_W  = 16;

	// front arithmetic
	localparam int CTR_W  = 18;  // 2*pos + diameter, q.5
	localparam int DIFF_W = 19;  // signed centre difference
	localparam int SQ_W   = 35;  // one squared difference
	localparam int D2_W   = 36;  // squared centre distance
	localparam int SUM_W  = 15;  // sum of diameters
	localparam int SS_W   = 30;  // its square

	// back arithmetic, valid on contact only
	localparam int ND_W   = 17;  // centre difference in contact range
	localparam int D2C_W  = 32;  // squared distance in contact range
	localparam int MSUM_W = 17;
	localparam int VD_W   = 17;
	localparam int PK_W   = 34;
	localparam int K_W    = 35;
	localparam int KM_W   = 34;
	localparam int DM_W   = 16;
	localparam int PM_W   = 50;
	localparam int PL_W   = 25;  // low part of a split product
	localparam int PH_W   = PM_W - PL_W;
	localparam int MF_W   = 17;
	localparam int PP_W   = PL_W + MF_W;
	localparam int DEN_W  = 49;
	localparam int NUM_W  = 66;
	localparam int Q_W    = 18;  // quotient never reaches 2^18
	localparam int RES_W  = 20;
	localparam int NSHARE = 4;

	// share index: first disc x, first disc y, second disc x, second disc y
	localparam int SH_AX = 0;
	localparam int SH_AY = 1;
	localparam int SH_BX = 2;
	localparam int SH_BY = 3;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 32;

	typedef struct packed {
		logic [POS_W-1:0]         a_pos_x;
		logic [POS_W-1:0]         a_pos_y;
		logic [DIAM_W-1:0]        a_diameter;
		logic [MASS_W-1:0]        a_mass;
		logic signed [VEL_W-1:0]  a_vel_x;
		logic signed [VEL_W-1:0]  a_vel_y;
		logic [POS_W-1:0]         b_pos_x;
		logic [POS_W-1:0]         b_pos_y;
		logic [DIAM_W-1:0]        b_diameter;
		logic [MASS_W-1:0]        b_mass;
		logic signed [VEL_W-1:0]  b_vel_x;
		logic signed [VEL_W-1:0]  b_vel_y;
	} edc_pair_t;

	typedef struct packed {
		logic                     touching;
		logic signed [VEL_W-1:0]  a_new_vel_x;
		logic signed [VEL_W-1:0]  a_new_vel_y;
		logic signed [VEL_W-1:0]  b_new_vel_x;
		logic signed [VEL_W-1:0]  b_new_vel_y;
	} edc_result_t;

	typedef struct packed {
		logic                     touch;
		logic                     apply;
		logic signed [ND_W-1:0]   dx;
		logic signed [ND_W-1:0]   dy;
		logic [D2C_W-1:0]         d2;
		logic [MASS_W-1:0]        ma;
		logic [MASS_W-1:0]        mb;
		logic signed [VEL_W-1:0]  vax;
		logic signed [VEL_W-1:0]  vay;
		logic signed [VEL_W-1:0]  vbx;
		logic signed [VEL_W-1:0]  vby;
	} edc_mid_t;

	typedef struct packed {
		logic                     touch;
		logic                     apply;
		logic                     negx;
		logic                     negy;
		logic signed [VEL_W-1:0]  vax;
		logic signed [VEL_W-1:0]  vay;
		logic signed [VEL_W-1:0]  vbx;
		logic signed [VEL_W-1:0]  vby;
	} edc_side_t;

endpackage

// ----- rtl/edc_fifo.sv -----
module edc_fifo #(
	parameter int W     = 1,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               wdata,
	input  logic                       pop,
	output logic [W-1:0]               rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem [0:DEPTH-1];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign empty   = cnt_q == '0;
	assign full    = cnt_q == CW'(DEPTH);
	assign count   = cnt_q;
	assign rdata   = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/edc_front.sv -----
module edc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  edc_pkg::edc_pair_t  pair,
	input  logic                push,
	output logic                full,
	output logic                mid_push,
	output edc_pkg::edc_mid_t   mid_data,
	input  logic                mid_full
);

	logic                               en;
	logic                               accept;
	logic [edc_pkg::CTR_W-1:0]          cax, cay, cbx, cby;
	logic signed [edc_pkg::DIFF_W-1:0]  dx, dy;
	logic [edc_pkg::SUM_W-1:0]          sum;
	logic                               vld_s1, vld_s2;
	edc_pkg::edc_pair_t                 pair_s1, pair_s2;
	logic signed [edc_pkg::DIFF_W-1:0]  dx_s1, dy_s1, dx_s2, dy_s2;
	logic [edc_pkg::SUM_W-1:0]          sum_s1;
	logic signed [2*edc_pkg::DIFF_W-1:0] sqx, sqy;
	logic [edc_pkg::SQ_W-1:0]           dxx_s2, dyy_s2;
	logic [edc_pkg::SS_W-1:0]           ss_s2;
	logic [edc_pkg::D2_W-1:0]           d2;
	logic [edc_pkg::MSUM_W-1:0]         msum;
	logic                               touch;

	assign en     = !vld_s2 || !mid_full;
	assign full   = !en;
	assign accept = push && en;

	// centres in q.5 pixels
	assign cax = edc_pkg::CTR_W'({pair.a_pos_x, 1'b0}) + edc_pkg::CTR_W'(pair.a_diameter);
	assign cay = edc_pkg::CTR_W'({pair.a_pos_y, 1'b0}) + edc_pkg::CTR_W'(pair.a_diameter);
	assign cbx = edc_pkg::CTR_W'({pair.b_pos_x, 1'b0}) + edc_pkg::CTR_W'(pair.b_diameter);
	assign cby = edc_pkg::CTR_W'({pair.b_pos_y, 1'b0}) + edc_pkg::CTR_W'(pair.b_diameter);
	assign dx  = $signed({1'b0, cax}) - $signed({1'b0, cbx});
	assign dy  = $signed({1'b0, cay}) - $signed({1'b0, cby});
	assign sum = edc_pkg::SUM_W'(pair.a_diameter) + edc_pkg::SUM_W'(pair.b_diameter);

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= pair;
			dx_s1   <= dx;
			dy_s1   <= dy;
			sum_s1  <= sum;
			pair_s2 <= pair_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dxx_s2  <= sqx[edc_pkg::SQ_W-1:0];
			dyy_s2  <= sqy[edc_pkg::SQ_W-1:0];
			ss_s2   <= sum_s1 * sum_s1;
		end
	end

	// classify: contact, and whether an exchange along the normal applies
	assign d2    = edc_pkg::D2_W'(dxx_s2) + edc_pkg::D2_W'(dyy_s2);
	assign touch = d2 <= edc_pkg::D2_W'(ss_s2);
	assign msum  = edc_pkg::MSUM_W'(pair_s2.a_mass) + edc_pkg::MSUM_W'(pair_s2.b_mass);

	always_comb begin
		mid_data.touch = touch;
		mid_data.apply = touch && (d2 != '0) && (msum != '0);
		mid_data.dx    = dx_s2[edc_pkg::ND_W-1:0];
		mid_data.dy    = dy_s2[edc_pkg::ND_W-1:0];
		mid_data.d2    = d2[edc_pkg::D2C_W-1:0];
		mid_data.ma    = pair_s2.a_mass;
		mid_data.mb    = pair_s2.b_mass;
		mid_data.vax   = pair_s2.a_vel_x;
		mid_data.vay   = pair_s2.a_vel_y;
		mid_data.vbx   = pair_s2.b_vel_x;
		mid_data.vby   = pair_s2.b_vel_y;
	end

	assign mid_push = vld_s2 && !mid_full;

endmodule

// ----- rtl/edc_div.sv -----
module edc_div (
	input  logic                       clk,
	input  logic [edc_pkg::NUM_W-1:0]  num,
	input  logic [edc_pkg::DEN_W-1:0]  den,
	output logic [edc_pkg::Q_W-1:0]    quo
);

	localparam int QW = edc_pkg::Q_W;
	localparam int NW = edc_pkg::NUM_W;
	localparam int DW = edc_pkg::DEN_W;

	logic [NW-1:0] rem_q [0:QW-2];
	logic [DW-1:0] den_q [0:QW-2];
	logic [QW-1:0] quo_q [0:QW-1];

	// one restoring step per stage, quotient msb first
	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [NW-1:0] r_in;
		logic [NW-1:0] t;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[j-1];
			assign d_in = den_q[j-1];
			assign q_in = quo_q[j-1];
		end

		assign t = NW'(d_in) << (QW - 1 - j);

		always_ff @(posedge clk) begin
			quo_q[j] <= (r_in >= t) ? (q_in | (QW'(1) << (QW - 1 - j))) : q_in;
		end

		if (j < QW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				rem_q[j] <= (r_in >= t) ? r_in - t : r_in;
				den_q[j] <= d_in;
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

// ----- rtl/edc_back.sv -----
module edc_back #(
	parameter int OUT_DEPTH = edc_pkg::OUT_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           mid_empty,
	input  edc_pkg::edc_mid_t              mid_data,
	output logic                           mid_pop,
	output logic                           out_push,
	output edc_pkg::edc_result_t           out_data,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count
);

	localparam int CW  = $clog2(OUT_DEPTH + 1);
	localparam int LAT = 6 + edc_pkg::Q_W;
	localparam int QW  = edc_pkg::Q_W;
	localparam int NS  = edc_pkg::NSHARE;

	logic                                issue;
	logic [CW-1:0]                       inflight_q;
	logic                                vld_q [0:LAT-1];

	edc_pkg::edc_mid_t                   m_s1, m_s2, m_s3, m_s4, m_s5;
	logic signed [edc_pkg::VD_W-1:0]     vdx_s1, vdy_s1;
	logic [edc_pkg::MSUM_W-1:0]          msum_s1;
	logic signed [edc_pkg::PK_W-1:0]     pkx_s2, pky_s2;
	logic [edc_pkg::DEN_W-1:0]           den_s2, den_s3, den_s4, den_s5, den_s6;
	logic signed [edc_pkg::K_W-1:0]      k;
	logic [edc_pkg::KM_W-1:0]            kmag_s3;
	logic                                kneg_s3;
	logic [edc_pkg::DM_W-1:0]            dxm_s3, dym_s3;
	logic                                dxneg_s3, dyneg_s3;
	logic [edc_pkg::PM_W-1:0]            pmx_s4, pmy_s4;
	logic                                negx_s4, negy_s4, negx_s5, negy_s5;
	logic [edc_pkg::PP_W-1:0]            pl_s5 [0:NS-1];
	logic [edc_pkg::PP_W-1:0]            ph_s5 [0:NS-1];
	logic [edc_pkg::NUM_W-1:0]           num_s6 [0:NS-1];
	edc_pkg::edc_side_t                  side_s6;
	edc_pkg::edc_side_t                  side_q [0:QW-1];
	logic [edc_pkg::Q_W-1:0]             quo [0:NS-1];
	edc_pkg::edc_side_t                  sd;

	function automatic logic signed [edc_pkg::VEL_W-1:0] sat_vel(
		input logic signed [edc_pkg::RES_W-1:0] v
	);
		logic signed [edc_pkg::RES_W-1:0] hi;
		logic signed [edc_pkg::RES_W-1:0] lo;
		hi = edc_pkg::RES_W'(2 ** (edc_pkg::VEL_W - 1) - 1);
		lo = -hi - 1'b1;
		if (v > hi) begin
			return hi[edc_pkg::VEL_W-1:0];
		end else if (v < lo) begin
			return lo[edc_pkg::VEL_W-1:0];
		end
		return v[edc_pkg::VEL_W-1:0];
	endfunction

	function automatic logic signed [edc_pkg::VEL_W-1:0] apply_share(
		input logic signed [edc_pkg::VEL_W-1:0] v,
		input logic [edc_pkg::Q_W-1:0]          q,
		input logic                             neg,
		input logic                             sub
	);
		logic signed [edc_pkg::RES_W-1:0] sh;
		logic signed [edc_pkg::RES_W-1:0] ve;
		sh = $signed(edc_pkg::RES_W'(q));
		if (neg ^ sub) begin
			sh = -sh;
		end
		ve = edc_pkg::RES_W'(v);
		return sat_vel(ve + sh);
	endfunction

	// credit: every request issued has a slot waiting in the result queue
	assign issue   = !mid_empty &&
		((CW + 1)'(inflight_q) + (CW + 1)'(out_count) < (CW + 1)'(OUT_DEPTH));
	assign mid_pop  = issue;
	assign out_push = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= issue;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
			case ({issue, out_push})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	assign k = $signed({pkx_s2[edc_pkg::PK_W-1], pkx_s2}) +
		$signed({pky_s2[edc_pkg::PK_W-1], pky_s2});

	always_ff @(posedge clk) begin
		// s1: velocity difference, mass sum
		m_s1    <= mid_data;
		vdx_s1  <= $signed({mid_data.vax[edc_pkg::VEL_W-1], mid_data.vax}) -
			$signed({mid_data.vbx[edc_pkg::VEL_W-1], mid_data.vbx});
		vdy_s1  <= $signed({mid_data.vay[edc_pkg::VEL_W-1], mid_data.vay}) -
			$signed({mid_data.vby[edc_pkg::VEL_W-1], mid_data.vby});
		msum_s1 <= edc_pkg::MSUM_W'(mid_data.ma) + edc_pkg::MSUM_W'(mid_data.mb);

		// s2: dot product terms, denominator
		m_s2   <= m_s1;
		pkx_s2 <= vdx_s1 * m_s1.dx;
		pky_s2 <= vdy_s1 * m_s1.dy;
		den_s2 <= msum_s1 * m_s1.d2;

		// s3: magnitudes and signs
		m_s3     <= m_s2;
		den_s3   <= den_s2;
		kneg_s3  <= k[edc_pkg::K_W-1];
		kmag_s3  <= k[edc_pkg::K_W-1] ? edc_pkg::KM_W'(-k) : edc_pkg::KM_W'(k);
		dxneg_s3 <= m_s2.dx[edc_pkg::ND_W-1];
		dyneg_s3 <= m_s2.dy[edc_pkg::ND_W-1];
		dxm_s3   <= m_s2.dx[edc_pkg::ND_W-1] ?
			edc_pkg::DM_W'(-m_s2.dx) : edc_pkg::DM_W'(m_s2.dx);
		dym_s3   <= m_s2.dy[edc_pkg::ND_W-1] ?
			edc_pkg::DM_W'(-m_s2.dy) : edc_pkg::DM_W'(m_s2.dy);

		// s4: k times normal component
		m_s4    <= m_s3;
		den_s4  <= den_s3;
		pmx_s4  <= edc_pkg::PM_W'(kmag_s3 * dxm_s3);
		pmy_s4  <= edc_pkg::PM_W'(kmag_s3 * dym_s3);
		negx_s4 <= kneg_s3 ^ dxneg_s3;
		negy_s4 <= kneg_s3 ^ dyneg_s3;

		// s5: split products by twice the other mass
		m_s5    <= m_s4;
		den_s5  <= den_s4;
		negx_s5 <= negx_s4;
		negy_s5 <= negy_s4;
		for (int i = 0; i < NS; i++) begin
			logic [edc_pkg::PM_W-1:0] pm;
			logic [edc_pkg::MF_W-1:0] mf;
			pm = (i == edc_pkg::SH_AX || i == edc_pkg::SH_BX) ? pmx_s4 : pmy_s4;
			mf = (i == edc_pkg::SH_AX || i == edc_pkg::SH_AY) ?
				{m_s4.mb, 1'b0} : {m_s4.ma, 1'b0};
			pl_s5[i] <= pm[edc_pkg::PL_W-1:0] * mf;
			ph_s5[i] <= pm[edc_pkg::PM_W-1:edc_pkg::PL_W] * mf;
		end

		// s6: numerators with half the denominator for rounding
		den_s6        <= den_s5;
		side_s6.touch <= m_s5.touch;
		side_s6.apply <= m_s5.apply;
		side_s6.negx  <= negx_s5;
		side_s6.negy  <= negy_s5;
		side_s6.vax   <= m_s5.vax;
		side_s6.vay   <= m_s5.vay;
		side_s6.vbx   <= m_s5.vbx;
		side_s6.vby   <= m_s5.vby;
		for (int i = 0; i < NS; i++) begin
			num_s6[i] <= edc_pkg::NUM_W'({ph_s5[i], {edc_pkg::PL_W{1'b0}}}) +
				edc_pkg::NUM_W'(pl_s5[i]) + edc_pkg::NUM_W'(den_s5 >> 1);
		end

		side_q[0] <= side_s6;
		for (int i = 1; i < QW; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_div
		edc_div u_div (
			.clk (clk),
			.num (num_s6[i]),
			.den (den_s6),
			.quo (quo[i])
		);
	end

	assign sd = side_q[QW-1];

	always_comb begin
		out_data.touching = sd.touch;
		if (sd.apply) begin
			out_data.a_new_vel_x = apply_share(sd.vax, quo[edc_pkg::SH_AX], sd.negx, 1'b1);
			out_data.a_new_vel_y = apply_share(sd.vay, quo[edc_pkg::SH_AY], sd.negy, 1'b1);
			out_data.b_new_vel_x = apply_share(sd.vbx, quo[edc_pkg::SH_BX], sd.negx, 1'b0);
			out_data.b_new_vel_y = apply_share(sd.vby, quo[edc_pkg::SH_BY], sd.negy, 1'b0);
		end else begin
			out_data.a_new_vel_x = sd.vax;
			out_data.a_new_vel_y = sd.vay;
			out_data.b_new_vel_x = sd.vbx;
			out_data.b_new_vel_y = sd.vby;
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(inflight_q) + (CW + 1)'(out_count) <= (CW + 1)'(OUT_DEPTH))
		else $error("result queue overcommitted");

	a_push_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> inflight_q != '0)
		else $error("result without an issued request");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && !issue |=> inflight_q == $past(inflight_q) - 1'b1)
		else $error("in-flight count lost a result");

endmodule

// ----- rtl/elastic_disc_collision_unit.sv -----
// elastic collision of two discs, one request per cycle while full is low
// input channel: pair carries both discs; a request is taken on a clock edge
// with push high and full low
// result channel: result shows the oldest finished request while empty is low;
// it is taken on an edge with pop high and empty low
// path of a request: two front stages, the classify queue, six arithmetic
// stages and an 18 stage restoring divider, one quotient bit a stage, then the
// result queue
// throughput: one request per cycle sustained while the receiver pops, set
// by the divider pipeline, which takes a new numerator every cycle
// the back issues a request only while the result queue has a free slot for
// it, so when the receiver stalls the result queue fills, then the classify
// queue, and full rises; nothing is dropped and no request is repeated
// reset: arst_n low clears both queues and all valid bits at once; no
// clearing pass, ready to accept in the first cycle after release
module elastic_disc_collision_unit #(
	parameter int MID_DEPTH = edc_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = edc_pkg::OUT_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  edc_pkg::edc_pair_t    pair,
	input  logic                  push,
	output logic                  full,
	output edc_pkg::edc_result_t  result,
	output logic                  empty,
	input  logic                  pop
);

	logic                           mid_push;
	edc_pkg::edc_mid_t              mid_data;
	logic                           mid_full;
	logic                           mid_pop;
	logic                           mid_empty;
	edc_pkg::edc_mid_t              mid_head;
	logic                           out_push;
	edc_pkg::edc_result_t           out_data;
	logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

	edc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair),
		.push     (push),
		.full     (full),
		.mid_push (mid_push),
		.mid_data (mid_data),
		.mid_full (mid_full)
	);

	edc_fifo #(
		.W     ($bits(edc_pkg::edc_mid_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_data),
		.pop    (mid_pop),
		.rdata  (mid_head),
		.empty  (mid_empty),
		.full   (mid_full),
		.count  ()
	);

	edc_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_head),
		.mid_pop   (mid_pop),
		.out_push  (out_push),
		.out_data  (out_data),
		.out_count (out_count)
	);

	edc_fifo #(
		.W     ($bits(edc_pkg::edc_result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_data),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty),
		.full   (),
		.count  (out_count)
	);

endmodule

// ----- test/elastic_disc_collision_unit_test.sv -----
module elastic_disc_collision_unit_test;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	edc_pkg::edc_pair_t pair = '0;
	logic push = 1'b0;
	logic full;
	edc_pkg::edc_result_t result;
	logic empty;
	logic pop = 1'b0;

	edc_pkg::edc_result_t expected_velocities[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	int checked_count = 0;
	int touch_count = 0;
	int pairs_sent = 0;

	always #6 clk = ~clk;

	elastic_disc_collision_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pair(pair),
		.push(push),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	function automatic logic signed [edc_pkg::VEL_W-1:0] clamp_vel(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[edc_pkg::VEL_W-1:0];
	endfunction

	// rounded mfac*p/den, ties away from zero
	function automatic longint mass_share(longint p, longint unsigned mfac,
			longint unsigned den);
		logic neg;
		longint unsigned mag;
		longint unsigned q;
		neg = p < 0;
		mag = neg ? longint'(-p) : longint'(p);
		mag = mag * mfac;
		q = (mag + den / 2) / den;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic edc_pkg::edc_result_t collide(edc_pkg::edc_pair_t p);
		edc_pkg::edc_result_t r;
		longint dx, dy, d2, s, k;
		longint vax, vay, vbx, vby, nax, nay, nbx, nby;
		longint unsigned ma, mb, den;
		dx = 2 * longint'(p.a_pos_x) + longint'(p.a_diameter)
			- 2 * longint'(p.b_pos_x) - longint'(p.b_diameter);
		dy = 2 * longint'(p.a_pos_y) + longint'(p.a_diameter)
			- 2 * longint'(p.b_pos_y) - longint'(p.b_diameter);
		s = longint'(p.a_diameter) + longint'(p.b_diameter);
		ma = longint'(p.a_mass);
		mb = longint'(p.b_mass);
		vax = longint'(p.a_vel_x);
		vay = longint'(p.a_vel_y);
		vbx = longint'(p.b_vel_x);
		vby = longint'(p.b_vel_y);
		d2 = dx * dx + dy * dy;
		nax = vax;
		nay = vay;
		nbx = vbx;
		nby = vby;
		r.touching = d2 <= s * s;
		if (r.touching && d2 != 0 && ma + mb != 0) begin
			k = (vax - vbx) * dx + (vay - vby) * dy;
			den = (ma + mb) * longint'(d2);
			nax = vax - mass_share(k * dx, 2 * mb, den);
			nay = vay - mass_share(k * dy, 2 * mb, den);
			nbx = vbx + mass_share(k * dx, 2 * ma, den);
			nby = vby + mass_share(k * dy, 2 * ma, den);
		end
		r.a_new_vel_x = clamp_vel(nax);
		r.a_new_vel_y = clamp_vel(nay);
		r.b_new_vel_x = clamp_vel(nbx);
		r.b_new_vel_y = clamp_vel(nby);
		return r;
	endfunction

	// push stays high after the request so the next one can follow at once
	task automatic send_pair(edc_pkg::edc_pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		pair <= p;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_velocities.push_back(collide(p));
		pairs_sent++;
		@(negedge clk);
	endtask

	// receiver: pop at random, check at the rising edge
	always @(negedge clk)
		pop <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		edc_pkg::edc_result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_velocities.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				want = expected_velocities.pop_front();
				checked_count++;
				if (result.touching)
					touch_count++;
				if (result.touching !== want.touching) begin
					$error("touching: expected %0b actual %0b", want.touching,
						result.touching);
					fail_count++;
				end
				if (result.a_new_vel_x !== want.a_new_vel_x) begin
					$error("a_new_vel_x: expected %0d actual %0d", want.a_new_vel_x,
						result.a_new_vel_x);
					fail_count++;
				end
				if (result.a_new_vel_y !== want.a_new_vel_y) begin
					$error("a_new_vel_y: expected %0d actual %0d", want.a_new_vel_y,
						result.a_new_vel_y);
					fail_count++;
				end
				if (result.b_new_vel_x !== want.b_new_vel_x) begin
					$error("b_new_vel_x: expected %0d actual %0d", want.b_new_vel_x,
						result.b_new_vel_x);
					fail_count++;
				end
				if (result.b_new_vel_y !== want.b_new_vel_y) begin
					$error("b_new_vel_y: expected %0d actual %0d", want.b_new_vel_y,
						result.b_new_vel_y);
					fail_count++;
				end
			end
		end
	end

	function automatic edc_pkg::edc_pair_t random_pair();
		edc_pkg::edc_pair_t p;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		p = raw[$bits(edc_pkg::edc_pair_t)-1:0];
		if (p.a_mass == '0)
			p.a_mass = 16'd1;
		if (p.b_mass == '0)
			p.b_mass = 16'd1;
		return p;
	endfunction

	// second disc placed near the first so most pairs touch
	function automatic edc_pkg::edc_pair_t near_pair();
		edc_pkg::edc_pair_t p;
		int span;
		p = random_pair();
		case ($urandom_range(3))
			0: begin
				p.a_diameter = 14'($urandom_range(64));
				p.b_diameter = 14'($urandom_range(64));
			end
			1: begin
				p.a_mass = 16'($urandom_range(1, 4));
				p.b_mass = 16'($urandom_range(1, 65535));
			end
			default: ;
		endcase
		span = (int'(p.a_diameter) + int'(p.b_diameter)) / 2 + 1;
		p.a_pos_x = 16'($urandom_range(16384, 49151));
		p.a_pos_y = 16'($urandom_range(16384, 49151));
		p.b_pos_x = 16'(int'(p.a_pos_x) + int'($urandom_range(2 * span)) - span);
		p.b_pos_y = 16'(int'(p.a_pos_y) + int'($urandom_range(2 * span)) - span);
		return p;
	endfunction

	task automatic wait_drained();
		push <= 1'b0;
		while (expected_velocities.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		edc_pkg::edc_pair_t p;
		p = '0;
		p.a_mass = 16'd1;
		p.b_mass = 16'd1;
		send_pair(p);  // coincident centres, zero size
		p.a_diameter = 14'd16383;
		p.b_diameter = 14'd16383;
		p.a_vel_x = 16'sh7fff;
		p.b_vel_x = 16'sh8000;
		send_pair(p);  // coincident, big discs
		p.b_pos_x = 16'd16383;
		p.a_mass = 16'd65535;
		send_pair(p);  // head-on exactly touching, saturating
		p.a_mass = 16'd1;
		p.b_mass = 16'd65535;
		p.a_vel_y = 16'sh8000;
		p.b_vel_y = 16'sh7fff;
		send_pair(p);
		p.b_pos_x = 16'd16384;
		send_pair(p);  // just apart
		p = '1;
		send_pair(p);
		p.b_pos_x = '0;
		p.b_pos_y = '0;
		send_pair(p);  // far apart, extremes
		p = '0;
		p.a_diameter = 14'd160;
		p.b_diameter = 14'd160;
		p.a_pos_x = 16'd100;
		p.b_pos_x = 16'd200;
		p.b_pos_y = 16'd60;
		p.a_mass = 16'd3;
		p.b_mass = 16'd5;
		p.a_vel_x = 16'sd640;
		p.b_vel_x = -16'sd320;
		p.a_vel_y = 16'sd77;
		send_pair(p);  // oblique contact
		p.a_mass = '0;
		send_pair(p);  // one massless disc
		p.b_mass = '0;
		send_pair(p);  // both massless
		wait_drained();
	endtask

	task automatic test_random(int n);
		repeat (n) begin
			if ($urandom_range(9) < 8)
				send_pair(near_pair());
			else
				send_pair(random_pair());
		end
	endtask

	task automatic test_pause_until_drained();
		test_random(20);
		wait_drained();
		test_random(20);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		send_idle_pct = 7;
		recv_idle_pct = 88;
		test_random(220);
		send_idle_pct = 88;
		recv_idle_pct = 7;
		test_random(220);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_pause_until_drained();
		test_random(200);
		wait_drained();
		repeat (40) @(negedge clk);
		$display("sent %0d pairs, checked %0d results, %0d of them in contact",
			pairs_sent, checked_count, touch_count);
		if (fail_count == 0 && expected_velocities.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/edc_pkg.sv
rtl/edc_fifo.sv
rtl/edc_front.sv
rtl/edc_div.sv
rtl/edc_back.sv
rtl/elastic_disc_collision_unit.sv
test/elastic_disc_collision_unit_test.sv
